// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, command and status types shared by the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  // The remainder unit retires two product bits per cycle.
  localparam int RED_CYCLES   = PROD_BITS / 2;
  localparam int CNT_BITS     = $clog2(RED_CYCLES);
  localparam int IN_TDATA_BITS  = ((2 * OPERAND_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OPERAND_BITS + 7) / 8) * 8;

  typedef logic [OPERAND_BITS-1:0] opnd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item and reset the accumulator
    logic mul;       // form a product and clear the remainder
    logic mul_acc;   // product is acc * base (else base * base)
    logic red;       // one remainder step, two product bits
    logic wr_acc;    // remainder goes to the accumulator
    logic wr_base;   // remainder goes to the running base
    logic shift;     // drop the lowest exponent bit
    logic out_load;  // copy the accumulator into the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
  } mexp_sts_t;

endpackage

// ----- rtl/core/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// Usage: write the modulus on the cfg channel (always ready) while the block
// is idle; it resets to 1 and a written zero acts as 1. Each item on the in
// stream carries a base and an exponent; one item with the result leaves on
// the out stream.
// Operation: one item is worked on at a time. The work scans the exponent from
// the lowest bit up to its highest set bit. A product takes a multiply step,
// the steps of the two-bit-per-cycle remainder unit and a write-back step; a
// squaring that follows a multiply into the accumulator starts in that
// write-back step. A clear bit needs a squaring, a set bit a multiply into
// the accumulator and then a squaring (only the multiply when it is the top
// bit). An exponent of zero skips all products.
// The result sits in an output register, so a new item is taken while the
// previous result still waits; if the receiver stalls, the finished result
// of the next item is held inside until the output register frees up.
// Reset (synchronous, active low) drops any item in flight and any pending
// result, and restores the modulus to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  mexp_pkg::opnd_t                      cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: base [30:0], exponent [61:31], zero fill [63:62]
  input  logic [mexp_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: power_mod [30:0], zero fill [31]
  output logic [mexp_pkg::OUT_TDATA_BITS-1:0]  out_tdata
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;
  opnd_t     power_mod;

  // The modulus register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mexp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .in_base     (in_tdata[OPERAND_BITS-1:0]),
    .in_exponent (in_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
    .cmd         (cmd),
    .sts         (sts),
    .power_mod   (power_mod)
  );

  assign out_tdata = OUT_TDATA_BITS'(power_mod);

  // After taking an item the block is busy until that item is finished.
  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  // A new result is loaded only on the way back to idle.
  `ASSERT_SAME(a_result_then_idle, $rose(out_tvalid), in_tready, "result without return to idle")
  // The exponent never runs out in the middle of a reduction.
  `ASSERT_SAME(a_exp_live_in_red, cmd.red, !sts.exp_zero, "reduction with exhausted exponent")

endmodule

// ----- rtl/core/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, one multiplier and a two-bit-per-cycle remainder unit.
// ----------------------------------------------------------------------------
module mexp_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  mexp_pkg::opnd_t       cfg_data,
  input  mexp_pkg::opnd_t       in_base,
  input  mexp_pkg::opnd_t       in_exponent,
  input  mexp_pkg::mexp_cmd_t   cmd,
  output mexp_pkg::mexp_sts_t   sts,
  output mexp_pkg::opnd_t       power_mod
);
  import mexp_pkg::*;

  opnd_t                 modulus_r;
  opnd_t                 wmod_r;
  opnd_t                 acc_r;
  opnd_t                 base_r;
  opnd_t                 exp_r;
  opnd_t                 rem_r;
  opnd_t                 out_r;
  logic [PROD_BITS-1:0]  prod_r;

  logic [PROD_BITS-1:0]    prod_nxt;
  logic [OPERAND_BITS:0]   mod_ext;
  logic [OPERAND_BITS:0]   t1;
  logic [OPERAND_BITS:0]   t2;
  opnd_t                   r1;
  opnd_t                   r2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= opnd_t'(1);
    end else if (cfg_we) begin
      modulus_r <= cfg_data;
    end
  end

  // Product of the selected operands, full double width.
  always_comb begin
    if (cmd.mul_acc) begin
      prod_nxt = PROD_BITS'(acc_r) * PROD_BITS'(base_r);
    end else begin
      prod_nxt = PROD_BITS'(base_r) * PROD_BITS'(base_r);
    end
  end

  // Restoring remainder: shift in one product bit, subtract if it fits, twice.
  always_comb begin
    mod_ext = {1'b0, wmod_r};
    t1 = {rem_r, prod_r[PROD_BITS-1]};
    if (t1 >= mod_ext) begin
      r1 = OPERAND_BITS'(t1 - mod_ext);
    end else begin
      r1 = t1[OPERAND_BITS-1:0];
    end
    t2 = {r1, prod_r[PROD_BITS-2]};
    if (t2 >= mod_ext) begin
      r2 = OPERAND_BITS'(t2 - mod_ext);
    end else begin
      r2 = t2[OPERAND_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= opnd_t'(1);
      base_r <= in_base;
      exp_r  <= in_exponent;
      // A zero modulus is handled as a modulus of one.
      wmod_r <= (modulus_r == '0) ? opnd_t'(1) : modulus_r;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      rem_r  <= '0;
    end else if (cmd.red) begin
      prod_r <= {prod_r[PROD_BITS-3:0], 2'b00};
      rem_r  <= r2;
    end
    if (cmd.wr_acc) begin
      acc_r <= rem_r;
    end
    if (cmd.wr_base) begin
      base_r <= rem_r;
    end
    if (cmd.shift) begin
      exp_r <= {1'b0, exp_r[OPERAND_BITS-1:1]};
    end
    if (cmd.out_load) begin
      out_r <= acc_r;
    end
  end

  assign sts.exp_zero      = (exp_r == '0);
  assign sts.exp_lsb       = exp_r[0];
  assign sts.exp_rest_zero = (exp_r[OPERAND_BITS-1:1] == '0);
  assign power_mod         = out_r;

endmodule

// ----- rtl/core/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply: steps the datapath bit by bit.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  mexp_pkg::mexp_sts_t   sts,
  output mexp_pkg::mexp_cmd_t   cmd
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_WRITE,
    ST_FINISH
  } state_t;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RED_CYCLES - 1);

  state_t              state_r, state_nxt;
  logic                phase_acc_r, phase_acc_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_acc_nxt = phase_acc_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          // Multiply into the accumulator when the bit is set, else square.
          cmd.mul       = 1'b1;
          cmd.mul_acc   = sts.exp_lsb;
          phase_acc_nxt = sts.exp_lsb;
          cnt_nxt       = '0;
          state_nxt     = ST_RED;
        end
      end
      ST_RED: begin
        cmd.red = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (phase_acc_r) begin
          cmd.wr_acc = 1'b1;
          if (sts.exp_rest_zero) begin
            // Highest set bit done; the final squaring is not needed.
            state_nxt = ST_FINISH;
          end else begin
            cmd.mul       = 1'b1;
            phase_acc_nxt = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = ST_RED;
          end
        end else begin
          cmd.wr_base = 1'b1;
          cmd.shift   = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_acc_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
